// ===== src/rhsm_pkg.sv =====
// Shared types and constants for the rolling-hash string matcher.
// Used by rhsm_ctrl, rhsm_dp and rolling_hash_string_matcher; depends on nothing.
`default_nettype none
package rhsm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int MOD_W       = 23;
	localparam int POS_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int BIT_W       = 3;
	localparam int CFG_IDX_W   = 1;

	localparam logic [MOD_W-1:0] MOD_RESET = 23'd101;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	// request commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TEXT  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PLEN    = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_DBL,
		OP_ADD,
		OP_NEGSUB,
		OP_SAVE_HP,
		OP_SAVE_PH,
		OP_TEXT_FIN,
		OP_DELIVER
	} op_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_PAT,
		SRC_VAL,
		SRC_W0
	} src_t;

	typedef struct packed {
		op_t              op;
		src_t             src;
		logic [IDX_W-1:0] byte_sel;
		logic [BIT_W-1:0] bit_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic             full;
		logic [LEN_W-1:0] len;
		logic             out_free;
	} ctrl_status_t;

endpackage
`default_nettype wire

// ===== src/rhsm_ctrl.sv =====
// Sequencing state machine for the rolling-hash string matcher.
// Drives datapath operations in rhsm_dp; uses types from rhsm_pkg.
`default_nettype none
module rhsm_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  rhsm_pkg::ctrl_status_t  stat,
	output rhsm_pkg::ctrl_cmd_t     ctl
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_DECODE = 11'b00000000010,
		ST_POW    = 11'b00000000100,
		ST_HP     = 11'b00000001000,
		ST_PHASH  = 11'b00000010000,
		ST_PH     = 11'b00000100000,
		ST_REM    = 11'b00001000000,
		ST_SUBT   = 11'b00010000000,
		ST_ROLL   = 11'b00100000000,
		ST_FIN    = 11'b01000000000,
		ST_DLV    = 11'b10000000000
	} state_t;

	localparam logic [rhsm_pkg::BIT_W-1:0] BIT_TOP = {rhsm_pkg::BIT_W{1'b1}};

	state_t                         state_q, state_d;
	logic [rhsm_pkg::IDX_W-1:0]     byte_q, byte_d;
	logic [rhsm_pkg::BIT_W-1:0]     bit_q, bit_d;
	logic [rhsm_pkg::BIT_W:0]       cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			byte_q  <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			byte_q  <= byte_d;
			bit_q   <= bit_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		byte_d       = byte_q;
		bit_d        = bit_q;
		cnt_d        = cnt_q;
		in_stall     = (state_q != ST_IDLE);
		ctl.op       = rhsm_pkg::OP_NONE;
		ctl.src      = rhsm_pkg::SRC_ZERO;
		ctl.byte_sel = byte_q;
		ctl.bit_sel  = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.op  = rhsm_pkg::OP_LATCH;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				byte_d = '0;
				bit_d  = BIT_TOP;
				cnt_d  = {(rhsm_pkg::BIT_W + 1){1'b1}};
				if (stat.cmd == rhsm_pkg::CMD_START) begin
					// a one-byte pattern needs no power steps
					state_d = (stat.len == rhsm_pkg::LEN_W'(1)) ? ST_HP : ST_POW;
				end else if (stat.cmd == rhsm_pkg::CMD_TEXT) begin
					state_d = stat.full ? ST_REM : ST_ROLL;
				end else begin
					state_d = ST_DLV;
				end
			end
			ST_POW: begin
				ctl.op = rhsm_pkg::OP_DBL;
				bit_d  = bit_q - 1'b1;
				if (bit_q == '0) begin
					if (rhsm_pkg::LEN_W'(byte_q) + rhsm_pkg::LEN_W'(2) == stat.len)
						state_d = ST_HP;
					else
						byte_d = byte_q + 1'b1;
				end
			end
			ST_HP: begin
				ctl.op  = rhsm_pkg::OP_SAVE_HP;
				byte_d  = '0;
				bit_d   = BIT_TOP;
				state_d = ST_PHASH;
			end
			ST_PHASH: begin
				ctl.op  = rhsm_pkg::OP_DBL;
				ctl.src = rhsm_pkg::SRC_PAT;
				bit_d   = bit_q - 1'b1;
				if (bit_q == '0) begin
					if (rhsm_pkg::LEN_W'(byte_q) + rhsm_pkg::LEN_W'(1) == stat.len)
						state_d = ST_PH;
					else
						byte_d = byte_q + 1'b1;
				end
			end
			ST_PH: begin
				ctl.op  = rhsm_pkg::OP_SAVE_PH;
				state_d = ST_DLV;
			end
			ST_REM: begin
				// alternate doubling and conditional add of the high power, MSB first
				ctl.bit_sel = cnt_q[rhsm_pkg::BIT_W:1];
				if (cnt_q[0]) begin
					ctl.op = rhsm_pkg::OP_DBL;
				end else begin
					ctl.op  = rhsm_pkg::OP_ADD;
					ctl.src = rhsm_pkg::SRC_W0;
				end
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = ST_SUBT;
			end
			ST_SUBT: begin
				ctl.op  = rhsm_pkg::OP_NEGSUB;
				bit_d   = BIT_TOP;
				state_d = ST_ROLL;
			end
			ST_ROLL: begin
				ctl.op  = rhsm_pkg::OP_DBL;
				ctl.src = rhsm_pkg::SRC_VAL;
				bit_d   = bit_q - 1'b1;
				if (bit_q == '0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				ctl.op  = rhsm_pkg::OP_TEXT_FIN;
				state_d = ST_DLV;
			end
			ST_DLV: begin
				if (stat.out_free) begin
					ctl.op  = rhsm_pkg::OP_DELIVER;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DECODE))
		else $error("accepted request not decoded");

	a_deliver_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == rhsm_pkg::OP_DELIVER) |-> stat.out_free)
		else $error("result delivered into a full output register");

	a_dlv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DLV && !stat.out_free) |=> (state_q == ST_DLV))
		else $error("result dropped while output stalled");

endmodule
`default_nettype wire

// ===== src/rhsm_dp.sv =====
// Datapath of the rolling-hash string matcher: config registers, pattern and window
// stores, bit-serial modular unit and result register. Uses rhsm_pkg.
`default_nettype none
module rhsm_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  write_enable,
	input  wire  [rhsm_pkg::CFG_IDX_W-1:0]       write_index,
	input  wire  [rhsm_pkg::MOD_W-1:0]           write_data,
	input  wire  [1:0]                           command,
	input  wire  [3:0]                           byte_index,
	input  wire  [rhsm_pkg::BYTE_W-1:0]          byte_value,
	input  rhsm_pkg::ctrl_cmd_t                  ctl,
	output rhsm_pkg::ctrl_status_t               stat,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 match_found,
	output logic                                 spurious_hit,
	output logic [rhsm_pkg::POS_W-1:0]           match_shift,
	output logic [rhsm_pkg::MOD_W-1:0]           window_hash
);

	localparam int N  = rhsm_pkg::MAX_PATTERN;
	localparam int MW = rhsm_pkg::MOD_W;
	localparam int LW = rhsm_pkg::LEN_W;

	logic [MW-1:0]                 modulus_q;
	logic [LW-1:0]                 plen_q;
	logic [rhsm_pkg::BYTE_W-1:0]   pat_q [N];
	logic [rhsm_pkg::BYTE_W-1:0]   win_q [N];
	logic [rhsm_pkg::BYTE_W-1:0]   win_up [N];
	logic [MW-1:0]                 ph_q, th_q, hp_q, acc_q, act_mod_q;
	logic [LW-1:0]                 fill_q, act_len_q;
	logic [rhsm_pkg::POS_W-1:0]    pos_q;
	logic [1:0]                    cmd_q;
	logic [rhsm_pkg::BYTE_W-1:0]   val_q;
	logic                          out_valid_q;
	logic                          match_q, spur_q;
	logic [rhsm_pkg::POS_W-1:0]    shift_q;
	logic [MW-1:0]                 whash_q;

	logic [MW-1:0]                 mod_eff;
	logic [LW-1:0]                 len_eff;
	logic                          full;
	logic [rhsm_pkg::BYTE_W-1:0]   sel_byte;
	logic                          sel_bit;
	logic [MW:0]                   mod_ext, dbl, sum;
	logic [MW-1:0]                 dbl_red, sum_red, neg_red, addend;
	logic [N-1:0]                  same_vec;
	logic                          same, text_full, hit;

	assign mod_eff  = (modulus_q == '0) ? MW'(1) : modulus_q;

	always_comb begin
		priority if (plen_q == '0)
			len_eff = LW'(1);
		else if (32'(plen_q) > N)
			len_eff = LW'(N);
		else
			len_eff = plen_q;
	end

	assign full = (fill_q >= act_len_q);

	always_comb begin
		unique case (ctl.src)
			rhsm_pkg::SRC_ZERO: sel_byte = '0;
			rhsm_pkg::SRC_PAT:  sel_byte = pat_q[ctl.byte_sel];
			rhsm_pkg::SRC_VAL:  sel_byte = val_q;
			rhsm_pkg::SRC_W0:   sel_byte = win_q[0];
			default:            sel_byte = '0;
		endcase
	end
	assign sel_bit = sel_byte[ctl.bit_sel];

	// one reduction step each: acc stays below the modulus
	assign mod_ext = {1'b0, act_mod_q};
	assign dbl     = {acc_q, sel_bit};
	assign dbl_red = (dbl >= mod_ext) ? MW'(dbl - mod_ext) : MW'(dbl);
	assign addend  = sel_bit ? hp_q : '0;
	assign sum     = {1'b0, acc_q} + {1'b0, addend};
	assign sum_red = (sum >= mod_ext) ? MW'(sum - mod_ext) : MW'(sum);
	assign neg_red = (th_q >= acc_q) ? (th_q - acc_q) : (th_q - acc_q + act_mod_q);

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_win
			if (gi < N - 1) begin : g_up
				assign win_up[gi] = win_q[gi + 1];
			end else begin : g_top
				assign win_up[gi] = '0;
			end
			assign same_vec[gi] = (LW'(gi) >= act_len_q) || (win_q[gi] == pat_q[gi]);
		end
	endgenerate

	assign same      = &same_vec;
	assign text_full = (cmd_q == rhsm_pkg::CMD_TEXT) && full;
	assign hit       = text_full && (th_q == ph_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= rhsm_pkg::MOD_RESET;
			plen_q      <= rhsm_pkg::LEN_RESET;
			ph_q        <= '0;
			th_q        <= '0;
			hp_q        <= MW'(1);
			acc_q       <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			act_len_q   <= rhsm_pkg::LEN_RESET;
			act_mod_q   <= rhsm_pkg::MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (write_enable) begin
				unique case (write_index)
					rhsm_pkg::REG_MODULUS: modulus_q <= write_data;
					rhsm_pkg::REG_PLEN:    plen_q    <= write_data[LW-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && ctl.op != rhsm_pkg::OP_DELIVER)
				out_valid_q <= 1'b0;
			unique case (ctl.op)
				rhsm_pkg::OP_LATCH: begin
					if (command == rhsm_pkg::CMD_START) begin
						act_len_q <= len_eff;
						act_mod_q <= mod_eff;
						acc_q     <= (mod_eff == MW'(1)) ? '0 : MW'(1);
					end else if (command == rhsm_pkg::CMD_TEXT) begin
						acc_q <= full ? '0 : th_q;
					end
				end
				rhsm_pkg::OP_DBL:    acc_q <= dbl_red;
				rhsm_pkg::OP_ADD:    acc_q <= sum_red;
				rhsm_pkg::OP_NEGSUB: acc_q <= neg_red;
				rhsm_pkg::OP_SAVE_HP: begin
					hp_q  <= acc_q;
					acc_q <= '0;
				end
				rhsm_pkg::OP_SAVE_PH: begin
					ph_q   <= acc_q;
					th_q   <= '0;
					fill_q <= '0;
					pos_q  <= '0;
				end
				rhsm_pkg::OP_TEXT_FIN: begin
					th_q  <= acc_q;
					pos_q <= pos_q + 1'b1;
					if (!full)
						fill_q <= fill_q + 1'b1;
				end
				rhsm_pkg::OP_DELIVER: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// window entries are always written before they are read, so they need no clear
	always_ff @(posedge clk) begin
		if (ctl.op == rhsm_pkg::OP_LATCH) begin
			cmd_q <= command;
			val_q <= byte_value;
			if (command == rhsm_pkg::CMD_LOAD && 32'(byte_index) < N)
				pat_q[rhsm_pkg::IDX_W'(byte_index)] <= byte_value;
		end
		if (ctl.op == rhsm_pkg::OP_TEXT_FIN) begin
			for (int i = 0; i < N; i++) begin
				if (full) begin
					if (LW'(i) == act_len_q - 1'b1)
						win_q[i] <= val_q;
					else if (LW'(i) < act_len_q - 1'b1)
						win_q[i] <= win_up[i];
				end else if (LW'(i) == fill_q) begin
					win_q[i] <= val_q;
				end
			end
		end
		if (ctl.op == rhsm_pkg::OP_DELIVER) begin
			match_q <= hit && same;
			spur_q  <= hit && !same;
			shift_q <= text_full ? (pos_q - rhsm_pkg::POS_W'(act_len_q)) : '0;
			whash_q <= th_q;
		end
	end

	assign stat.cmd      = cmd_q;
	assign stat.full     = full;
	assign stat.len      = act_len_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign match_found  = match_q;
	assign spurious_hit = spur_q;
	assign match_shift  = shift_q;
	assign window_hash  = whash_q;

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < act_mod_q)
		else $error("accumulator left unreduced");

	// a start swaps the modulus before the hash and fill are cleared
	a_hash_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == rhsm_pkg::OP_DELIVER) |-> (th_q < act_mod_q))
		else $error("window hash not below modulus");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == rhsm_pkg::OP_DELIVER) |-> (fill_q <= act_len_q))
		else $error("window fill overran pattern length");

	a_out_from_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.op == rhsm_pkg::OP_DELIVER))
		else $error("result raised without a delivery");

endmodule
`default_nettype wire

// ===== src/rolling_hash_string_matcher.sv =====
// Streaming rolling-hash string matcher, radix 256, configurable modulus.
// Top level: joins rhsm_ctrl and rhsm_dp; uses rhsm_pkg.
//
// Input channel (in_valid / in_stall): one request per accepted edge.
//   command LOAD writes byte_value to pattern entry byte_index.
//   command START latches modulus and pattern_length, works out the high power
//   and the pattern hash, and restarts the text position.
//   command TEXT rolls byte_value into the window hash and, once the window is
//   full, reports a match or a spurious hash hit with the window's start shift.
// Output channel (out_valid / out_stall): exactly one result per request.
// Configuration: write_enable / write_index / write_data, to be written by the user only while
//   idle (the block does not enforce this); new values apply at the next START.
// Request steps (the modular unit works one bit per cycle): LOAD latches, decodes and
//   delivers; TEXT also rolls the byte in bit by bit and, once the window is full, first
//   removes the oldest byte's share of the hash; START also works out the high power
//   and the pattern hash bit by bit before it delivers.
// One request is in flight at a time; in_stall is high until its result sits in
// the output register. A stalled result holds and blocks the next delivery only.
// Reset clears to modulus 101, length 1, high power 1, hashes and position 0.
`default_nettype none
module rolling_hash_string_matcher (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  write_enable,
	input  wire  [rhsm_pkg::CFG_IDX_W-1:0]       write_index,
	input  wire  [rhsm_pkg::MOD_W-1:0]           write_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [1:0]                           command,
	input  wire  [3:0]                           byte_index,
	input  wire  [7:0]                           byte_value,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 match_found,
	output logic                                 spurious_hit,
	output logic [31:0]                          match_shift,
	output logic [22:0]                          window_hash
);

	rhsm_pkg::ctrl_cmd_t    ctl;
	rhsm_pkg::ctrl_status_t stat;

	rhsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	rhsm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.command      (command),
		.byte_index   (byte_index),
		.byte_value   (byte_value),
		.ctl          (ctl),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.match_found  (match_found),
		.spurious_hit (spurious_hit),
		.match_shift  (match_shift),
		.window_hash  (window_hash)
	);

endmodule
`default_nettype wire
